// File: rtl/brd_pkg.sv
`default_nettype none

package brd_pkg;

   localparam int DATA_W        = 8;
   localparam int FILL_W        = 11;
   localparam int CAP_W         = 11;
   localparam int DEPTH_DEFAULT = 1024;
   localparam int CAP_RESET     = 1024;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type KIND_PUSH_BACK  = 2'd0;
   localparam kind_type KIND_PUSH_FRONT = 2'd1;
   localparam kind_type KIND_POP_BACK   = 2'd2;
   localparam kind_type KIND_POP_FRONT  = 2'd3;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_OVERFLOW  = 2'd1;
   localparam status_type STATUS_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// File: rtl/brd_ram.sv
`default_nettype none

module brd_ram #(
   parameter int DEPTH = brd_pkg::DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              addr,
   input  wire logic [brd_pkg::DATA_W-1:0] wr_data,
   output logic      [brd_pkg::DATA_W-1:0] rd_data
);
   import brd_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Single port: one write or one read per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/byte_ring_deque.sv
`default_nettype none

// Channel   Ports                                          Handshake
// --------  ---------------------------------------------  -------------------------------
// request   req_kind, req_data, req_block_last             taken when start && !busy
// response  rsp_popped, rsp_status, rsp_occupancy,         one cycle, marked by rsp_strobe
//           rsp_block_done
// config    csr_wdata                                      written when csr_we is high
//
// Each word makes at most one access to the single-port byte memory: the address is
// issued at the accepting edge and the response appears in the next cycle,
// so a new word is accepted every cycle and busy never rises.
// Reset is synchronous and active high; it empties the deque and sets the
// capacity to its reset value. The receiver cannot stall the response.

module byte_ring_deque #(
   parameter int DEPTH = brd_pkg::DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Request channel.
   input  wire logic                       start,
   output logic                            busy,
   input  wire brd_pkg::kind_type          req_kind,
   input  wire logic [brd_pkg::DATA_W-1:0] req_data,
   input  wire logic                       req_block_last,
   // Response channel.
   output logic                            rsp_strobe,
   output logic      [brd_pkg::DATA_W-1:0] rsp_popped,
   output brd_pkg::status_type             rsp_status,
   output logic      [brd_pkg::FILL_W-1:0] rsp_occupancy,
   output logic                            rsp_block_done,
   // Configuration: capacity register.
   input  wire logic                       csr_we,
   input  wire logic [brd_pkg::CAP_W-1:0]  csr_wdata
);
   import brd_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Width wide enough to compare a fill count against a pointer value.
   localparam int CMP_W = (AW > FILL_W) ? AW : FILL_W;
   localparam logic [AW-1:0] CAP_M1_RESET =
      (CAP_RESET > DEPTH) ? AW'(DEPTH - 1) : AW'(CAP_RESET - 1);

   // The capacity is kept as (effective capacity - 1), already clamped to
   // the range 1..DEPTH, so the wrap tests compare against it directly.
   logic [AW-1:0]     cap_m1_ff, cap_m1_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              rsp_strobe_ff;
   status_type        status_ff, status_in;
   logic              pop_ok_ff, pop_ok_in;
   logic [FILL_W-1:0] occupancy_ff;
   logic              done_ff;

   logic              accept;
   logic              full;
   logic              empty;
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_addr;
   logic [DATA_W-1:0] mem_rdata;

   // Forward step: wrap to zero at or beyond the last slot.
   function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] idx,
                                              input logic [AW-1:0] last);
      logic [AW-1:0] nxt;
      nxt = idx + AW'(1);
      if (idx >= last) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   // Backward step: from zero, or from beyond the last slot, go to the last slot.
   function automatic logic [AW-1:0] step_bwd(input logic [AW-1:0] idx,
                                              input logic [AW-1:0] last);
      logic [AW-1:0] nxt;
      nxt = idx - AW'(1);
      if (idx == '0 || idx > last) begin
         nxt = last;
      end
      return nxt;
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // A push is refused once fill reaches the effective capacity.
   assign full  = CMP_W'(fill_ff) > CMP_W'(cap_m1_ff);
   assign empty = (fill_ff == '0);

   // Capacity write: zero acts as one, and anything above DEPTH saturates.
   always_comb begin
      cap_m1_in = cap_m1_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            cap_m1_in = '0;
         end else if (32'(csr_wdata) > DEPTH) begin
            cap_m1_in = AW'(DEPTH - 1);
         end else begin
            cap_m1_in = AW'(csr_wdata - CAP_W'(1));
         end
      end
   end

   // Pointer and fill update, plus the memory access for the accepted word.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      status_in = STATUS_OK;
      pop_ok_in = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = tail_ff;
      if (accept) begin
         unique case (req_kind)
            KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = tail_ff;
                  tail_in  = step_fwd(tail_ff, cap_m1_ff);
                  fill_in  = fill_ff + FILL_W'(1);
               end
            end
            KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = step_bwd(head_ff, cap_m1_ff);
                  head_in  = mem_addr;
                  fill_in  = fill_ff + FILL_W'(1);
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  mem_re    = 1'b1;
                  pop_ok_in = 1'b1;
                  mem_addr  = step_bwd(tail_ff, cap_m1_ff);
                  tail_in   = mem_addr;
                  fill_in   = fill_ff - FILL_W'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  mem_re    = 1'b1;
                  pop_ok_in = 1'b1;
                  mem_addr  = head_ff;
                  head_in   = step_fwd(head_ff, cap_m1_ff);
                  fill_in   = fill_ff - FILL_W'(1);
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_m1_ff     <= CAP_M1_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cap_m1_ff     <= cap_m1_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Response payload, registered at the accepting edge; the memory registers the popped byte at the same edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         pop_ok_ff    <= pop_ok_in;
         occupancy_ff <= fill_in;
         done_ff      <= req_block_last;
      end
   end

   brd_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (req_data),
      .rd_data (mem_rdata)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_popped     = pop_ok_ff ? mem_rdata : '0;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occupancy_ff;
   assign rsp_block_done = done_ff;

endmodule

`default_nettype wire

// File: tb/sv/byte_ring_deque_test.sv
`timescale 1ns / 1ps

import brd_pkg::*;

// One response word as the deque should present it.
typedef struct {
   logic [DATA_W-1:0] popped;
   status_type        status;
   logic [FILL_W-1:0] occupancy;
   logic              block_done;
} deque_result_type;

// Keeps its own copy of the ring (bytes, indices, fill, capacity) and the
// queue of response words still owed by the block.
class deque_scoreboard;
   logic [DATA_W-1:0] byte_store [DEPTH_DEFAULT];
   bit                stored     [DEPTH_DEFAULT];
   int unsigned       head_ix;
   int unsigned       tail_ix;
   int unsigned       fill_count;
   int unsigned       capacity_reg;
   deque_result_type  owed_results [$];
   int unsigned       errors;
   int unsigned       words;
   int unsigned       results;
   int unsigned       overflows;
   int unsigned       underflows;
   int unsigned       peak_fill;

   function new();
      head_ix      = 0;
      tail_ix      = 0;
      fill_count   = 0;
      capacity_reg = CAP_RESET;
      errors       = 0;
      words        = 0;
      results      = 0;
      overflows    = 0;
      underflows   = 0;
      peak_fill    = 0;
      foreach (stored[i]) begin
         stored[i]     = 1'b0;
         byte_store[i] = '0;
      end
   endfunction

   function void set_capacity(int unsigned value);
      capacity_reg = value & 11'h7FF;
   endfunction

   // Zero behaves as one, anything past the memory depth saturates.
   function int unsigned usable_capacity();
      int unsigned c;
      c = capacity_reg & 11'h7FF;
      if (c == 0) return 1;
      if (c > DEPTH_DEFAULT) return DEPTH_DEFAULT;
      return c;
   endfunction

   function int unsigned step_up(int unsigned i);
      return (i + 1 >= usable_capacity()) ? 0 : i + 1;
   endfunction

   function int unsigned step_down(int unsigned i);
      int unsigned c;
      c = usable_capacity();
      if (i == 0 || i > c) return c - 1;
      return i - 1;
   endfunction

   function bit pop_is_defined(kind_type kind);
      if (fill_count == 0) return 1'b1;
      if (kind == KIND_POP_BACK) return stored[step_down(tail_ix)];
      return stored[head_ix];
   endfunction

   // A pop that would land on a byte never written is swapped for the other
   // pop, or for a push if both ends are undefined.
   function kind_type safe_kind(kind_type kind);
      if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) return kind;
      if (pop_is_defined(kind)) return kind;
      if (kind == KIND_POP_BACK && pop_is_defined(KIND_POP_FRONT)) return KIND_POP_FRONT;
      if (kind == KIND_POP_FRONT && pop_is_defined(KIND_POP_BACK)) return KIND_POP_BACK;
      return KIND_PUSH_BACK;
   endfunction

   function void note_word(kind_type kind, logic [DATA_W-1:0] data, logic last);
      deque_result_type r;
      r.popped = '0;
      r.status = STATUS_OK;
      words++;
      if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) begin
         if (fill_count >= usable_capacity()) begin
            r.status = STATUS_OVERFLOW;
            overflows++;
         end else if (kind == KIND_PUSH_BACK) begin
            byte_store[tail_ix] = data;
            stored[tail_ix]     = 1'b1;
            tail_ix             = step_up(tail_ix);
            fill_count++;
         end else begin
            head_ix             = step_down(head_ix);
            byte_store[head_ix] = data;
            stored[head_ix]     = 1'b1;
            fill_count++;
         end
      end else begin
         if (fill_count == 0) begin
            r.status = STATUS_UNDERFLOW;
            underflows++;
         end else if (kind == KIND_POP_BACK) begin
            tail_ix  = step_down(tail_ix);
            r.popped = byte_store[tail_ix];
            fill_count--;
         end else begin
            r.popped = byte_store[head_ix];
            head_ix  = step_up(head_ix);
            fill_count--;
         end
      end
      if (fill_count > peak_fill) peak_fill = fill_count;
      r.occupancy  = fill_count[FILL_W-1:0];
      r.block_done = last;
      owed_results.push_back(r);
   endfunction

   task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task check_result(logic [DATA_W-1:0] popped, status_type status,
                     logic [FILL_W-1:0] occupancy, logic block_done);
      deque_result_type want;
      results++;
      if (owed_results.size() == 0) begin
         report($sformatf("stray result: popped %02h status %0d occupancy %0d",
                          popped, status, occupancy));
         return;
      end
      want = owed_results.pop_front();
      if (popped !== want.popped)
         report($sformatf("result %0d popped %02h, wanted %02h",
                          results, popped, want.popped));
      if (status !== want.status)
         report($sformatf("result %0d status %0d, wanted %0d",
                          results, status, want.status));
      if (occupancy !== want.occupancy)
         report($sformatf("result %0d occupancy %0d, wanted %0d",
                          results, occupancy, want.occupancy));
      if (block_done !== want.block_done)
         report($sformatf("result %0d block_done %b, wanted %b",
                          results, block_done, want.block_done));
   endtask
endclass

module byte_ring_deque_test;

   // Nothing in a healthy run sits idle longer than a sender gap plus the
   // pause around a capacity write, so a quiet stretch that reaches the limit means a hang.
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   kind_type            req_kind;
   logic [DATA_W-1:0]   req_data;
   logic                req_block_last;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_popped;
   status_type          rsp_status;
   logic [FILL_W-1:0]   rsp_occupancy;
   logic                rsp_block_done;
   logic                csr_we;
   logic [CAP_W-1:0]    csr_wdata;

   deque_scoreboard     sb;
   int unsigned         settings_used;
   int unsigned         quiet_cycles;

   byte_ring_deque #(
      .DEPTH(DEPTH_DEFAULT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_data       (req_data),
      .req_block_last (req_block_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_popped     (rsp_popped),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_block_done (rsp_block_done),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every response is compared as it goes by; the receiver has no way to
   // hold it, so the strobe alone marks the word.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_result(rsp_popped, rsp_status, rsp_occupancy, rsp_block_done);
      end
   end

   // Watchdog: any cycle that moves a word in either direction clears it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Presents one request word and holds it until the block takes it. The
   // word is noted in the scoreboard at the accepting edge, which also keeps
   // the model state current for picking the next word. With no gap, start
   // simply stays high into the next word.
   task automatic issue_word(input kind_type kind, input logic [DATA_W-1:0] data,
                             input logic last, input int unsigned gap);
      kind_type k;
      k = sb.safe_kind(kind);
      start          <= 1'b1;
      req_kind       <= k;
      req_data       <= data;
      req_block_last <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(k, data, last);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Capacity may only change while the block is quiet, so drop start,
   // let every owed response drain, and idle a little before the write.
   task automatic write_capacity(input int unsigned value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[CAP_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_capacity(value);
      settings_used++;
   endtask

   // A phase sets the capacity and then sends runs of same-kind bytes, the
   // way a multi-byte call is split up, with block_last on the final byte of
   // each run. A small share of words gets a flipped block_last as noise.
   // Some phases and some runs go back to back with no gaps at all.
   task automatic run_phase(input int unsigned cap, input int unsigned count,
                            input int unsigned push_pct);
      int unsigned sent;
      int unsigned run_len;
      int unsigned gap;
      bit          no_gaps;
      bit          tight_run;
      kind_type    kind;
      logic        last;
      sent = 0;
      write_capacity(cap);
      no_gaps = ($urandom_range(0, 3) == 0);
      while (sent < count) begin
         run_len   = $urandom_range(1, 8);
         tight_run = ($urandom_range(0, 9) < 3);
         if ($urandom_range(0, 99) < push_pct) begin
            kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         end else begin
            kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
         end
         for (int j = 0; j < run_len && sent < count; j++) begin
            last = (j == run_len - 1);
            if ($urandom_range(0, 9) == 0) last = ~last;
            gap = (no_gaps || tight_run) ? 0 : $urandom_range(0, 19);
            issue_word(kind, 8'($urandom_range(0, 255)), last, gap);
            sent++;
         end
      end
   endtask

   initial begin
      sb             = new();
      settings_used  = 0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_kind       <= KIND_PUSH_BACK;
      req_data       <= '0;
      req_block_last <= 1'b0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      quiet_cycles   <= 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset capacity first. Both pops on an empty
      // deque must underflow; then the byte extremes go in at the back and two
      // patterns at the front, with the front push wrapping the head backward past zero.
      issue_word(KIND_POP_BACK,   8'h00, 1'b1, 0);
      issue_word(KIND_POP_FRONT,  8'hFF, 1'b0, 3);
      issue_word(KIND_PUSH_BACK,  8'h00, 1'b0, 0);
      issue_word(KIND_PUSH_BACK,  8'hFF, 1'b1, 1);
      issue_word(KIND_PUSH_FRONT, 8'hA5, 1'b0, 0);
      issue_word(KIND_PUSH_FRONT, 8'h5A, 1'b1, 2);
      issue_word(KIND_POP_FRONT,  8'h00, 1'b0, 0);
      issue_word(KIND_POP_BACK,   8'h00, 1'b1, 0);
      issue_word(KIND_PUSH_BACK,  8'h3C, 1'b1, 0);

      // Shrink the capacity below the bytes held: pushes must overflow
      // while pops keep draining, and the head sits beyond the new limit.
      write_capacity(2);
      issue_word(KIND_PUSH_BACK,  8'h81, 1'b0, 0);
      issue_word(KIND_PUSH_FRONT, 8'h18, 1'b1, 0);
      issue_word(KIND_POP_FRONT,  8'h00, 1'b0, 1);
      issue_word(KIND_POP_BACK,   8'h00, 1'b0, 0);
      issue_word(KIND_POP_FRONT,  8'h00, 1'b1, 0);
      issue_word(KIND_POP_BACK,   8'h00, 1'b0, 0);

      // A capacity of zero behaves as one byte.
      write_capacity(0);
      issue_word(KIND_PUSH_BACK,  8'h77, 1'b0, 0);
      issue_word(KIND_PUSH_FRONT, 8'h66, 1'b1, 0);
      issue_word(KIND_POP_FRONT,  8'h00, 1'b1, 0);

      // An oversized value saturates at the memory depth, so a front push
      // from index zero must land on the last memory entry.
      write_capacity(2047);
      issue_word(KIND_PUSH_FRONT, 8'hC3, 1'b1, 0);
      issue_word(KIND_POP_BACK,   8'h00, 1'b1, 0);
      issue_word(KIND_POP_FRONT,  8'h00, 1'b0, 0);

      // Random part across small, odd, medium and saturated capacities.
      // The push share per phase swings so that full and empty both recur.
      run_phase(1,    60,  50);
      run_phase(2,    60,  50);
      run_phase(0,    40,  50);
      run_phase(3,    80,  60);
      run_phase(2047, 80,  50);
      run_phase(5,    100, 50);
      run_phase(16,   100, 65);
      run_phase(200,  300, 88);
      run_phase(1500, 80,  35);
      run_phase(7,    100, 25);
      run_phase(1024, 100, 55);
      run_phase($urandom_range(1, 64), 100, $urandom_range(30, 80));
      run_phase($urandom_range(1, 64), 100, $urandom_range(30, 80));

      // Let the last responses arrive, then a few more cycles to catch any
      // response that should not be there.
      start <= 1'b0;
      @(posedge clock);
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.owed_results.size() != 0) begin
         sb.report($sformatf("%0d responses never arrived", sb.owed_results.size()));
      end

      $display("Sent %0d words under %0d capacity writes; %0d overflows, %0d underflows.",
               sb.words, settings_used, sb.overflows, sb.underflows);
      $display("Checked %0d responses; deepest fill %0d bytes; %0d mismatches.",
               sb.results, sb.peak_fill, sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
